FILE: rtl/core/hsn_pkg.sv
// shared types and constants of the heightmap surface normal block
package hsn_pkg;

  localparam int GRID_REG_W = 11;
  localparam logic [GRID_REG_W-1:0] GRID_RESET = 11'd512;

  localparam logic REG_GRID_WIDTH = 1'b0;
  localparam logic REG_GRID_DEPTH = 1'b1;

  localparam int NB_LEFT  = 0;
  localparam int NB_RIGHT = 1;
  localparam int NB_BACK  = 2;
  localparam int NB_FRONT = 3;
  localparam int NB_NUM   = 4;

  localparam int DIFF_W   = 17;
  localparam int DIFF_LIM = 65535;
  localparam int MAG_W    = 16;
  localparam int LEN_W    = 32;
  localparam logic [LEN_W-1:0] VERT_SQ = 32'd65536;

  localparam int ROOT_BITS = 15;
  localparam int QUO_BITS  = 31;
  localparam int UNIT_LAT  = QUO_BITS + ROOT_BITS;

  localparam int SUM_W = 18;
  localparam int SSQ_W = 35;

  localparam logic [ROOT_BITS-1:0] ROOT_ONE = 15'h7fff;

  typedef struct packed {
    logic [NB_NUM-1:0] pres;
    logic [NB_NUM-1:0] neg;
  } nb_side_t;

  typedef struct packed {
    logic neg_x;
    logic neg_z;
    logic fallback;
  } fin_side_t;

endpackage

FILE: rtl/core/heightmap_surface_normal.sv
// heightmap surface normal, top level
// one grid point per transaction: position, own height and four neighbour heights
// (signed Q8.8). start with busy low hands in a transaction; busy is high only
// while rst_n is low, so a new point can be given in every cycle.
// each result shows on the out_ ports for one cycle with out_valid high;
// results keep the input order.
// the path holds two rounds of ratio-and-root units, 46 stages each
// (31 restoring division steps, then 15 square root steps), plus 7 stages of
// difference, square and sum logic. throughput is one point per cycle.
// out_fallback high means no neighbour lay inside the grid and (0,1,0) was given.
// the receiver cannot hold results off and the pipeline never stalls.
// reset clears all valid bits, dropping points in flight, and sets grid_width and
// grid_depth to 512. grid_width is at byte address 0, grid_depth at 4 (APB port);
// write them only while no point is in flight.
module heightmap_surface_normal #(
  parameter int MAX_GRID    = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [$clog2(MAX_GRID)-1:0]            in_col,
  input  logic [$clog2(MAX_GRID)-1:0]            in_row,
  input  logic signed [HEIGHT_BITS-1:0]          in_center_height,
  input  logic signed [HEIGHT_BITS-1:0]          in_left_height,
  input  logic signed [HEIGHT_BITS-1:0]          in_right_height,
  input  logic signed [HEIGHT_BITS-1:0]          in_back_height,
  input  logic signed [HEIGHT_BITS-1:0]          in_front_height,
  output logic                                   out_valid,
  output logic signed [15:0]                     out_normal_x,
  output logic [14:0]                            out_normal_y,
  output logic signed [15:0]                     out_normal_z,
  output logic                                   out_fallback,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import hsn_pkg::*;

  localparam int CLW = $clog2(MAX_GRID);
  localparam int PW  = (CLW + 1 > GRID_REG_W) ? CLW + 1 : GRID_REG_W;
  localparam int HW  = HEIGHT_BITS + 1;
  localparam int CW  = (HW > DIFF_W + 1) ? HW : DIFF_W + 1;

  // configuration
  logic [GRID_REG_W-1:0] grid_width_r, grid_depth_r;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= GRID_RESET;
      grid_depth_r <= GRID_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_GRID_WIDTH: grid_width_r <= pwdata[GRID_REG_W-1:0];
        REG_GRID_DEPTH: grid_depth_r <= pwdata[GRID_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GRID_WIDTH: prdata = 32'(grid_width_r);
      REG_GRID_DEPTH: prdata = 32'(grid_depth_r);
      default:        prdata = '0;
    endcase
  end

  assign busy = ~rst_n;

  function automatic logic signed [DIFF_W-1:0] sat_diff(input logic signed [HW-1:0] v);
    logic signed [CW-1:0] e;
    logic signed [CW-1:0] lim;
    e   = CW'(v);
    lim = CW'(DIFF_LIM);
    if (e > lim) begin
      sat_diff = DIFF_W'(lim);
    end else if (e < -lim) begin
      sat_diff = DIFF_W'(-lim);
    end else begin
      sat_diff = e[DIFF_W-1:0];
    end
  endfunction

  // stage a: presence and saturated differences
  logic                     accept;
  logic [PW-1:0]            w_sat, d_sat, col_p1, row_p1;
  logic signed [HW-1:0]     ext_c;
  logic [NB_NUM-1:0]        pres_a;
  logic signed [DIFF_W-1:0] diff_a [NB_NUM];

  assign accept = start & ~busy;
  assign w_sat  = (PW'(grid_width_r) > PW'(MAX_GRID)) ? PW'(MAX_GRID) : PW'(grid_width_r);
  assign d_sat  = (PW'(grid_depth_r) > PW'(MAX_GRID)) ? PW'(MAX_GRID) : PW'(grid_depth_r);
  assign col_p1 = PW'(in_col) + PW'(1);
  assign row_p1 = PW'(in_row) + PW'(1);
  assign ext_c  = HW'(in_center_height);

  assign pres_a[NB_LEFT]  = in_col != '0;
  assign pres_a[NB_RIGHT] = col_p1 < w_sat;
  assign pres_a[NB_BACK]  = in_row != '0;
  assign pres_a[NB_FRONT] = row_p1 < d_sat;

  assign diff_a[NB_LEFT]  = sat_diff(HW'(in_left_height) - ext_c);
  assign diff_a[NB_RIGHT] = sat_diff(ext_c - HW'(in_right_height));
  assign diff_a[NB_BACK]  = sat_diff(HW'(in_back_height) - ext_c);
  assign diff_a[NB_FRONT] = sat_diff(ext_c - HW'(in_front_height));

  logic                     a_vld_r;
  logic [NB_NUM-1:0]        a_pres_r;
  logic signed [DIFF_W-1:0] a_diff_r [NB_NUM];

  // stage b: magnitudes
  logic                     b_vld_r;
  logic [NB_NUM-1:0]        b_pres_r, b_neg_r;
  logic [MAG_W-1:0]         b_mag_r [NB_NUM];

  // stage c: squares and lengths
  logic                     c_vld_r;
  nb_side_t                 c_side_r;
  logic [LEN_W-1:0]         c_sq_r  [NB_NUM];
  logic [LEN_W-1:0]         c_len_r [NB_NUM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  for (genvar i = 0; i < NB_NUM; i++) begin : g_nb
    logic signed [DIFF_W-1:0] neg_d;
    logic [LEN_W-1:0]         sq;
    assign neg_d = -a_diff_r[i];
    assign sq    = LEN_W'(b_mag_r[i]) * LEN_W'(b_mag_r[i]);

    always_ff @(posedge clk) begin
      a_diff_r[i] <= diff_a[i];
      b_neg_r[i]  <= a_diff_r[i][DIFF_W-1];
      b_mag_r[i]  <= a_diff_r[i][DIFF_W-1] ? neg_d[MAG_W-1:0] : a_diff_r[i][MAG_W-1:0];
      c_sq_r[i]   <= sq;
      c_len_r[i]  <= sq + VERT_SQ;
    end
  end

  always_ff @(posedge clk) begin
    a_pres_r      <= pres_a;
    b_pres_r      <= a_pres_r;
    c_side_r.pres <= b_pres_r;
    c_side_r.neg  <= b_neg_r;
  end

  // per-neighbour unit vectors
  logic [ROOT_BITS-1:0] h_root [NB_NUM];
  logic [ROOT_BITS-1:0] v_root [NB_NUM];
  logic [NB_NUM-1:0]    h_vld, v_vld;

  for (genvar i = 0; i < NB_NUM; i++) begin : g_unit
    hsn_root_ratio #(.DW(LEN_W)) u_h (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (c_vld_r),
      .in_num   (c_sq_r[i]),
      .in_den   (c_len_r[i]),
      .out_vld  (h_vld[i]),
      .out_root (h_root[i])
    );
    hsn_root_ratio #(.DW(LEN_W)) u_v (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (c_vld_r),
      .in_num   (VERT_SQ),
      .in_den   (c_len_r[i]),
      .out_vld  (v_vld[i]),
      .out_root (v_root[i])
    );
  end

  nb_side_t nb_dly_r [UNIT_LAT];

  always_ff @(posedge clk) begin
    nb_dly_r[0] <= c_side_r;
    for (int k = 1; k < UNIT_LAT; k++) begin
      nb_dly_r[k] <= nb_dly_r[k-1];
    end
  end

  // stage e: sum of unit vectors
  nb_side_t                nb_side;
  logic signed [SUM_W-1:0] hs [NB_NUM];
  logic signed [SUM_W-1:0] sx_e, sz_e;
  logic [SUM_W-1:0]        sy_e;

  assign nb_side = nb_dly_r[UNIT_LAT-1];

  for (genvar i = 0; i < NB_NUM; i++) begin : g_hs
    logic signed [SUM_W-1:0] hv;
    assign hv    = SUM_W'(h_root[i]);
    assign hs[i] = !nb_side.pres[i] ? '0 : (nb_side.neg[i] ? -hv : hv);
  end

  assign sx_e = hs[NB_LEFT] + hs[NB_RIGHT];
  assign sz_e = hs[NB_BACK] + hs[NB_FRONT];

  always_comb begin
    sy_e = '0;
    for (int i = 0; i < NB_NUM; i++) begin
      if (nb_side.pres[i]) begin
        sy_e = sy_e + SUM_W'(v_root[i]);
      end
    end
  end

  logic                    e_vld_r, f_vld_r, g_vld_r;
  logic signed [SUM_W-1:0] e_sx_r, e_sz_r;
  logic [SUM_W-1:0]        e_sy_r;
  logic                    e_fb_r;
  fin_side_t               f_side_r, g_side_r;
  logic [SSQ_W-1:0]        f_sq_r [3];
  logic [SSQ_W-1:0]        g_sq_r [3];
  logic [SSQ_W-1:0]        g_s_r;
  logic [SUM_W-1:0]        mx_e, mz_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
    end else begin
      e_vld_r <= &{h_vld, v_vld};
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
    end
  end

  // stage f: squares of the sum, stage g: squared length
  assign mx_e = e_sx_r[SUM_W-1] ? SUM_W'(-e_sx_r) : SUM_W'(e_sx_r);
  assign mz_e = e_sz_r[SUM_W-1] ? SUM_W'(-e_sz_r) : SUM_W'(e_sz_r);

  always_ff @(posedge clk) begin
    e_sx_r            <= sx_e;
    e_sy_r            <= sy_e;
    e_sz_r            <= sz_e;
    e_fb_r            <= nb_side.pres == '0;
    f_sq_r[0]         <= SSQ_W'(mx_e) * SSQ_W'(mx_e);
    f_sq_r[1]         <= SSQ_W'(e_sy_r) * SSQ_W'(e_sy_r);
    f_sq_r[2]         <= SSQ_W'(mz_e) * SSQ_W'(mz_e);
    f_side_r.neg_x    <= e_sx_r[SUM_W-1];
    f_side_r.neg_z    <= e_sz_r[SUM_W-1];
    f_side_r.fallback <= e_fb_r;
    g_sq_r            <= f_sq_r;
    g_s_r             <= f_sq_r[0] + f_sq_r[1] + f_sq_r[2];
    g_side_r          <= f_side_r;
  end

  // normalization
  logic [ROOT_BITS-1:0] fin_root [3];
  logic [2:0]           fin_vld;

  for (genvar i = 0; i < 3; i++) begin : g_fin
    hsn_root_ratio #(.DW(SSQ_W)) u_n (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (g_vld_r),
      .in_num   (g_sq_r[i]),
      .in_den   (g_s_r),
      .out_vld  (fin_vld[i]),
      .out_root (fin_root[i])
    );
  end

  fin_side_t fin_dly_r [UNIT_LAT];

  always_ff @(posedge clk) begin
    fin_dly_r[0] <= g_side_r;
    for (int k = 1; k < UNIT_LAT; k++) begin
      fin_dly_r[k] <= fin_dly_r[k-1];
    end
  end

  // output stage
  fin_side_t            fin_side;
  logic signed [15:0]   nx_v, nz_v;
  logic                 out_valid_r, out_fallback_r;
  logic signed [15:0]   out_nx_r, out_nz_r;
  logic [14:0]          out_ny_r;

  assign fin_side = fin_dly_r[UNIT_LAT-1];
  assign nx_v     = 16'(fin_root[0]);
  assign nz_v     = 16'(fin_root[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= &fin_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_fallback_r <= fin_side.fallback;
    if (fin_side.fallback) begin
      out_nx_r <= '0;
      out_ny_r <= ROOT_ONE;
      out_nz_r <= '0;
    end else begin
      out_nx_r <= fin_side.neg_x ? -nx_v : nx_v;
      out_ny_r <= fin_root[1];
      out_nz_r <= fin_side.neg_z ? -nz_v : nz_v;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_normal_x = out_nx_r;
  assign out_normal_y = out_ny_r;
  assign out_normal_z = out_nz_r;
  assign out_fallback = out_fallback_r;

  a_fb_matches_sum: assert property (@(posedge clk) disable iff (!rst_n)
    e_vld_r |-> ((e_sy_r == '0) == e_fb_r))
    else $error("fallback flag disagrees with vertical sum");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    g_vld_r |-> (g_s_r != '0) || g_side_r.fallback)
    else $error("zero squared length without fallback");

  a_up_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fallback |-> out_normal_y != '0)
    else $error("normal has no vertical part");

endmodule

FILE: rtl/core/hsn_root_ratio.sv
// pipelined min(32767, isqrt(num * 2^30 / den)) for num <= den
module hsn_root_ratio #(
  parameter int DW = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [DW-1:0]                 in_num,
  input  logic [DW-1:0]                 in_den,
  output logic                          out_vld,
  output logic [hsn_pkg::ROOT_BITS-1:0] out_root
);
  import hsn_pkg::*;

  localparam int QW = QUO_BITS;
  localparam int RB = ROOT_BITS;
  localparam int TW = 2 * ROOT_BITS;

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW];
  logic          dvld_r [QW];

  logic [RB-1:0] rt_r  [RB];
  logic [TW-1:0] rt2_r [RB];
  logic [QW-1:0] rq_r  [RB];
  logic          rvld_r [RB];

  logic ge0;
  assign ge0 = in_num >= in_den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r[0] <= 1'b0;
    end else begin
      dvld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= ge0 ? in_num - in_den : in_num;
    quo_r[0] <= {{(QW-1){1'b0}}, ge0};
    den_r[0] <= in_den;
  end

  for (genvar k = 1; k < QW; k++) begin : g_div
    logic [DW:0] sh;
    logic        ge;
    logic [DW:0] diff;
    assign sh   = {rem_r[k-1], 1'b0};
    assign ge   = sh >= {1'b0, den_r[k-1]};
    assign diff = sh - {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[k] <= 1'b0;
      end else begin
        dvld_r[k] <= dvld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
      quo_r[k] <= {quo_r[k-1][QW-2:0], ge};
      den_r[k] <= den_r[k-1];
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_root
    localparam int B = RB - 1 - j;
    logic [RB-1:0] r_prev;
    logic [TW-1:0] r2_prev;
    logic [QW-1:0] q_prev;
    logic          v_prev;
    logic [TW-1:0] trial;
    logic          keep;

    if (j == 0) begin : g_first
      assign r_prev  = '0;
      assign r2_prev = '0;
      assign q_prev  = quo_r[QW-1];
      assign v_prev  = dvld_r[QW-1];
    end else begin : g_next
      assign r_prev  = rt_r[j-1];
      assign r2_prev = rt2_r[j-1];
      assign q_prev  = rq_r[j-1];
      assign v_prev  = rvld_r[j-1];
    end

    assign trial = r2_prev + (TW'(r_prev) << (B + 1)) + (TW'(1) << (2 * B));
    assign keep  = {1'b0, trial} <= q_prev;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rvld_r[j] <= 1'b0;
      end else begin
        rvld_r[j] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      rt_r[j]  <= keep ? (r_prev | (RB'(1) << B)) : r_prev;
      rt2_r[j] <= keep ? trial : r2_prev;
      rq_r[j]  <= q_prev;
    end
  end

  assign out_vld  = rvld_r[RB-1];
  assign out_root = rt_r[RB-1];

endmodule

FILE: verif/heightmap_surface_normal_tb.sv
// self-checking testbench for the heightmap surface normal block
module heightmap_surface_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsn_pkg::*;

  localparam int LATENCY = 99;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [9:0] col;
    logic [9:0] row;
    logic signed [15:0] c, l, r, b, f;
  } point_t;

  typedef struct {
    logic signed [15:0] nx;
    logic [14:0] ny;
    logic signed [15:0] nz;
    logic fb;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [9:0] in_col = '0, in_row = '0;
  logic signed [15:0] in_center_height = '0, in_left_height = '0, in_right_height = '0;
  logic signed [15:0] in_back_height = '0, in_front_height = '0;
  logic out_valid;
  logic signed [15:0] out_normal_x, out_normal_z;
  logic [14:0] out_normal_y;
  logic out_fallback;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  heightmap_surface_normal dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_col(in_col), .in_row(in_row), .in_center_height(in_center_height),
    .in_left_height(in_left_height), .in_right_height(in_right_height),
    .in_back_height(in_back_height), .in_front_height(in_front_height),
    .out_valid(out_valid), .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_fallback(out_fallback),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  point_t pending_points[$];
  normal_t expected_normals[$];
  logic [10:0] width_reg = GRID_RESET, depth_reg = GRID_RESET;
  int errors = 0, n_sent = 0, n_checked = 0, n_fallback = 0;
  int gap_cnt = 0, burst_cnt = 0, idle_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0, bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sat15(longint unsigned v);
    return v > 32767 ? 32767 : v;
  endfunction

  function automatic longint sat_diff(longint d);
    if (d > 65535) return 65535;
    if (d < -65535) return -65535;
    return d;
  endfunction

  function automatic longint scaled_root(longint c, longint unsigned s);
    longint unsigned mag = c < 0 ? -c : c;
    longint unsigned m = sat15(int_sqrt(((mag * mag) << 30) / s));
    return c < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic normal_t surface_normal(point_t p);
    normal_t n;
    longint sx = 0, sy = 0, sz = 0;
    longint d[4];
    bit pres[4];
    bit is_z[4];
    longint unsigned w = width_reg > 1024 ? 1024 : width_reg;
    longint unsigned dp = depth_reg > 1024 ? 1024 : depth_reg;
    longint unsigned mag, sq, len, s;
    d[0] = sat_diff(longint'(p.l) - p.c);
    d[1] = sat_diff(longint'(p.c) - p.r);
    d[2] = sat_diff(longint'(p.b) - p.c);
    d[3] = sat_diff(longint'(p.c) - p.f);
    pres[0] = p.col > 0;
    pres[1] = longint'(p.col) + 1 < w;
    pres[2] = p.row > 0;
    pres[3] = longint'(p.row) + 1 < dp;
    is_z = '{0, 0, 1, 1};
    for (int i = 0; i < 4; i++) begin
      if (pres[i]) begin
        mag = d[i] < 0 ? -d[i] : d[i];
        sq = mag * mag;
        len = sq + 65536;
        mag = sat15(int_sqrt((sq << 30) / len));
        if (is_z[i]) sz += d[i] < 0 ? -longint'(mag) : longint'(mag);
        else sx += d[i] < 0 ? -longint'(mag) : longint'(mag);
        sy += longint'(sat15(int_sqrt((64'd65536 << 30) / len)));
      end
    end
    if (sy == 0) begin
      n.nx = '0; n.ny = 15'd32767; n.nz = '0; n.fb = 1'b1;
    end else begin
      s = sx * sx + sy * sy + sz * sz;
      n.nx = 16'(scaled_root(sx, s));
      n.ny = 15'(scaled_root(sy, s));
      n.nz = 16'(scaled_root(sz, s));
      n.fb = 1'b0;
    end
    return n;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  // driver: bursts with random gaps
  always @(posedge clk) begin
    point_t p;
    if (start && !busy) begin
      p.col = in_col; p.row = in_row; p.c = in_center_height; p.l = in_left_height;
      p.r = in_right_height; p.b = in_back_height; p.f = in_front_height;
      expected_normals.push_back(surface_normal(p));
      n_sent++;
    end
    if (!(start && busy)) begin
      if (gap_cnt > 0 || pending_points.size() == 0) begin
        if (gap_cnt > 0) gap_cnt--;
        start <= 1'b0;
      end else begin
        p = pending_points.pop_front();
        in_col <= p.col; in_row <= p.row; in_center_height <= p.c;
        in_left_height <= p.l; in_right_height <= p.r;
        in_back_height <= p.b; in_front_height <= p.f;
        start <= 1'b1;
        if (burst_cnt > 0) begin
          burst_cnt--;
        end else begin
          burst_cnt = $urandom_range(40, 0);
          gap_cnt = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 0);
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    normal_t e;
    if (out_valid && rst_n) begin
      if (expected_normals.size() == 0) begin
        $display("unexpected result transaction");
        errors++;
      end else begin
        e = expected_normals.pop_front();
        if (out_normal_x !== e.nx) report_mismatch("normal_x", out_normal_x, e.nx);
        if (out_normal_y !== e.ny) report_mismatch("normal_y", out_normal_y, e.ny);
        if (out_normal_z !== e.nz) report_mismatch("normal_z", out_normal_z, e.nz);
        if (out_fallback !== e.fb) report_mismatch("fallback", out_fallback, e.fb);
        if (e.fb) n_fallback++;
        n_checked++;
      end
    end
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog timeout");
      $display("heightmap_surface_normal_tb failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) width_reg = data[10:0];
    else if (addr == 3'd4) depth_reg = data[10:0];
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0 || start || expected_normals.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_height();
    case ($urandom_range(4, 0))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(1024, 0) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] rand_coord(logic [10:0] ext);
    int lim = ext == 0 ? 1 : (ext > 1024 ? 1024 : ext);
    case ($urandom_range(5, 0))
      0: return 10'd0;
      1: return 10'(lim - 1);
      2: return 10'(lim);
      3: return 10'($urandom);
      default: return 10'($urandom_range(lim - 1, 0));
    endcase
  endfunction

  task automatic add_point(int col, int row, int c, int l, int r, int b, int f);
    point_t p;
    p.col = 10'(col); p.row = 10'(row);
    p.c = 16'(c); p.l = 16'(l); p.r = 16'(r); p.b = 16'(b); p.f = 16'(f);
    pending_points.push_back(p);
  endtask

  task automatic add_random(int count);
    point_t p;
    for (int i = 0; i < count; i++) begin
      p.col = rand_coord(width_reg); p.row = rand_coord(depth_reg);
      p.c = rand_height(); p.l = rand_height(); p.r = rand_height();
      p.b = rand_height(); p.f = rand_height();
      pending_points.push_back(p);
    end
  endtask

  initial begin
    logic [10:0] widths[8];
    logic [10:0] depths[8];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed points at reset geometry
    add_point(5, 5, 0, 0, 0, 0, 0);
    add_point(0, 0, 0, 0, 0, 0, 0);
    add_point(511, 511, 100, -100, 300, 7, -7);
    add_point(1023, 1023, 0, 0, 0, 0, 0);
    add_point(10, 10, -32768, 32767, 32767, 32767, 32767);
    add_point(10, 10, 32767, -32768, -32768, -32768, -32768);
    add_point(3, 7, 256, 0, 512, 256, 0);
    add_point(0, 200, -32768, -32768, 32767, -32768, 32767);
    add_point(200, 0, 1, 2, 3, 4, 5);
    add_point(511, 0, -1, 0, -2, 0, -3);
    wait_drained();
    widths = '{11'd1, 11'd1024, 11'd2047, 11'd0, 11'd2, 11'd1025, 11'd3, 11'd700};
    depths = '{11'd1, 11'd1024, 11'd2047, 11'd0, 11'd1, 11'd1, 11'd2, 11'd33};
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(3'd0, {21'($urandom), widths[ph]});
      cfg_write(3'd4, {21'($urandom), depths[ph]});
      add_point(0, 0, 0, 32767, -32768, 32767, -32768);
      add_point(1023, 1023, -32768, 32767, 32767, 32767, 32767);
      add_random(ph < 3 ? 40 : 120);
      wait_drained();
    end
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(3'd0, $urandom_range(2047, 0));
      cfg_write(3'd4, $urandom_range(2047, 0));
      add_random(150);
      wait_drained();
    end
    $display("%0d grid points checked (%0d fallback) over 13 grid settings incl. 0, 1, 2047",
             n_checked, n_fallback);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("heightmap_surface_normal_tb passed");
    end else begin
      $display("heightmap_surface_normal_tb failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/hsn_pkg.sv
rtl/core/hsn_root_ratio.sv
rtl/core/heightmap_surface_normal.sv
verif/heightmap_surface_normal_tb.sv
